// ----- rtl/utf8_stream_decoder_defines.svh -----
// Assertion helpers for utf8_stream_decoder.sv, the one file that checks itself.
// Both macros expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTF8SD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/utf8sd_pkg.sv -----
package utf8sd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_MAX         = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] CP_MIN_LEN2    = 21'h000080;
    localparam logic [20:0] CP_MIN_LEN3    = 21'h000800;
    localparam logic [20:0] CP_MIN_LEN4    = 21'h010000;

    // Byte class as decided by the front end.
    typedef enum logic [2:0] {
        KIND_ASCII = 3'd0,
        KIND_LEAD2 = 3'd1,
        KIND_LEAD3 = 3'd2,
        KIND_LEAD4 = 3'd3,
        KIND_CONT  = 3'd4,
        KIND_BAD   = 3'd5
    } t_kind;

    // Classified byte: payload bits are already masked for the byte's class.
    typedef struct packed {
        t_kind      kind;
        logic [6:0] payload;
        logic       last;
    } t_token;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- rtl/utf8sd_ifs.sv -----
interface utf8sd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utf8sd_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        is_error;

    modport source (output valid, output code_point, output is_error, input ready);
    modport sink   (input valid, input code_point, input is_error, output ready);
endinterface

// ----- rtl/utf8sd_front.sv -----
module utf8sd_front (
    utf8sd_byte_if.sink            i_byte,
    input  utf8sd_pkg::t_q_status  i_q_status,
    output logic                   o_push,
    output utf8sd_pkg::t_token     o_token
);

    function automatic utf8sd_pkg::t_token classify(input logic [7:0] b, input logic last);
        utf8sd_pkg::t_token t;
        t.last    = last;
        t.payload = 7'd0;
        if (b[7] == 1'b0) begin
            t.kind    = utf8sd_pkg::KIND_ASCII;
            t.payload = b[6:0];
        end else if (b[7:6] == 2'b10) begin
            t.kind    = utf8sd_pkg::KIND_CONT;
            t.payload = {1'b0, b[5:0]};
        end else if (b[7:5] == 3'b110) begin
            t.kind    = utf8sd_pkg::KIND_LEAD2;
            t.payload = {2'b00, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            t.kind    = utf8sd_pkg::KIND_LEAD3;
            t.payload = {3'b000, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            t.kind    = utf8sd_pkg::KIND_LEAD4;
            t.payload = {4'b0000, b[2:0]};
        end else begin
            t.kind = utf8sd_pkg::KIND_BAD;
        end
        return t;
    endfunction

    assign i_byte.ready = !i_q_status.full;
    assign o_push       = i_byte.valid && !i_q_status.full;
    assign o_token      = classify(i_byte.data_byte, i_byte.end_of_string);

endmodule

// ----- rtl/utf8sd_queue.sv -----
module utf8sd_queue #(
    parameter int DEPTH = utf8sd_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  utf8sd_pkg::t_token     i_token,
    input  logic                   i_pop,
    output utf8sd_pkg::t_token     o_token,
    output utf8sd_pkg::t_q_status  o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8sd_pkg::t_token r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    assign o_token        = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ----- rtl/utf8sd_back.sv -----
module utf8sd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  utf8sd_pkg::t_q_status  i_q_status,
    input  utf8sd_pkg::t_token     i_token,
    output logic                   o_pop,
    utf8sd_cp_if.source            o_cp
);

    logic [20:0] r_partial, n_partial;
    logic [1:0]  r_left,    n_left;
    logic [2:0]  r_len,     n_len;
    logic        r_err,     n_err;
    logic        r_out_valid;
    logic [20:0] r_cp;
    logic        r_is_error;

    logic        w_emit;
    logic        w_fail;
    logic [20:0] w_emit_cp;
    logic [20:0] w_acc;

    function automatic logic scalar_ok(input logic [20:0] cp, input logic [2:0] len);
        logic [20:0] minimum;
        case (len)
            3'd2:    minimum = utf8sd_pkg::CP_MIN_LEN2;
            3'd3:    minimum = utf8sd_pkg::CP_MIN_LEN3;
            default: minimum = utf8sd_pkg::CP_MIN_LEN4;
        endcase
        return (cp >= minimum)
            && !(cp >= utf8sd_pkg::CP_SURR_LO && cp <= utf8sd_pkg::CP_SURR_HI)
            && (cp <= utf8sd_pkg::CP_MAX);
    endfunction

    // The queue head moves on whenever the queue holds an entry and the output register is free or being emptied.
    assign o_pop = !i_q_status.empty && (!r_out_valid || o_cp.ready);
    assign w_acc = {r_partial[14:0], i_token.payload[5:0]};

    always_comb begin
        n_partial = r_partial;
        n_left    = r_left;
        n_len     = r_len;
        n_err     = r_err;
        w_emit    = 1'b0;
        w_fail    = 1'b0;
        w_emit_cp = '0;
        if (o_pop && !r_err) begin
            if (r_left == 2'd0) begin
                case (i_token.kind)
                    utf8sd_pkg::KIND_ASCII: begin
                        w_emit    = 1'b1;
                        w_emit_cp = {14'd0, i_token.payload};
                    end
                    utf8sd_pkg::KIND_LEAD2: begin
                        n_partial = {16'd0, i_token.payload[4:0]};
                        n_left    = 2'd1;
                        n_len     = 3'd2;
                    end
                    utf8sd_pkg::KIND_LEAD3: begin
                        n_partial = {17'd0, i_token.payload[3:0]};
                        n_left    = 2'd2;
                        n_len     = 3'd3;
                    end
                    utf8sd_pkg::KIND_LEAD4: begin
                        n_partial = {18'd0, i_token.payload[2:0]};
                        n_left    = 2'd3;
                        n_len     = 3'd4;
                    end
                    default: begin
                        w_fail = 1'b1;
                    end
                endcase
            end else if (i_token.kind != utf8sd_pkg::KIND_CONT) begin
                w_fail = 1'b1;
            end else begin
                n_partial = w_acc;
                n_left    = r_left - 2'd1;
                if (r_left == 2'd1) begin
                    if (scalar_ok(w_acc, r_len)) begin
                        w_emit    = 1'b1;
                        w_emit_cp = w_acc;
                        n_partial = '0;
                        n_len     = '0;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
            end
            // A string that ends inside a sequence is reported on its last byte.
            if (i_token.last && !w_emit && !w_fail && n_left != 2'd0) begin
                w_fail = 1'b1;
            end
            if (w_fail) begin
                w_emit    = 1'b1;
                w_emit_cp = utf8sd_pkg::CP_REPLACEMENT;
                n_err     = 1'b1;
                n_partial = '0;
                n_left    = '0;
                n_len     = '0;
            end
        end
        if (o_pop && i_token.last) begin
            n_partial = '0;
            n_left    = '0;
            n_len     = '0;
            n_err     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_left      <= '0;
            r_len       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_partial <= n_partial;
            r_left    <= n_left;
            r_len     <= n_len;
            r_err     <= n_err;
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_cp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_cp       <= w_emit_cp;
            r_is_error <= w_fail;
        end
    end

    assign o_cp.valid      = r_out_valid;
    assign o_cp.code_point = r_cp;
    assign o_cp.is_error   = r_is_error;

endmodule

// ----- rtl/utf8_stream_decoder.sv -----
// UTF-8 stream decoder.
// The byte channel i_byte carries one raw byte per transfer, with end_of_string set on
// the last byte of a string. The code point channel o_cp carries one decoded scalar value
// per transfer, or U+FFFD with is_error set when the encoding is invalid or truncated.
// After an error the rest of the string produces nothing; end_of_string clears all state.
// A front end classifies each byte and writes it into a short queue; the back end takes
// one entry per cycle while the output register is free or being emptied, updates the
// sequence state and loads the output register. Throughput is one byte per cycle while
// o_cp.ready stays high. A byte accepted at i_byte is written into the queue; the back
// end pops it from the queue head and, once its code point is complete, loads it into
// the output register. When the receiver holds o_cp.ready low the back end stops once the
// output register is full, the queue fills behind it and i_byte.ready drops; nothing is
// lost. Reset (i_rst_n low, synchronous) empties the queue and the output register and
// clears the sequence state; the block is ready for bytes as soon as reset is released.
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = utf8sd_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utf8sd_byte_if.sink  i_byte,
    utf8sd_cp_if.source  o_cp
);

    utf8sd_pkg::t_q_status w_q_status;
    utf8sd_pkg::t_token    w_push_token;
    utf8sd_pkg::t_token    w_head_token;
    logic                  w_push;
    logic                  w_pop;

    utf8sd_front u_front (
        .i_byte     (i_byte),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_token    (w_push_token)
    );

    utf8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_token  (w_push_token),
        .i_pop    (w_pop),
        .o_token  (w_head_token),
        .o_status (w_q_status)
    );

    utf8sd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_token    (w_head_token),
        .o_pop      (w_pop),
        .o_cp       (o_cp)
    );

    `UTF8SD_ASSERT_NOW(a_error_is_replacement, o_cp.valid && o_cp.is_error,
        o_cp.code_point == utf8sd_pkg::CP_REPLACEMENT, "error result is not U+FFFD")
    `UTF8SD_ASSERT_NOW(a_scalar_valid, o_cp.valid && !o_cp.is_error,
        (o_cp.code_point <= utf8sd_pkg::CP_MAX)
            && !((o_cp.code_point >= utf8sd_pkg::CP_SURR_LO)
            && (o_cp.code_point <= utf8sd_pkg::CP_SURR_HI)),
        "decoded value is not a scalar value")
    `UTF8SD_ASSERT_NOW(a_queue_status, 1'b1, !(w_q_status.full && w_q_status.empty),
        "queue reports full and empty together")
    `UTF8SD_ASSERT_NEXT(a_stalled_pop, o_cp.valid && !o_cp.ready, !w_pop || o_cp.ready,
        "queue popped while the output register stays blocked")

endmodule
